/* rtl/pbm_pkg.sv */
`default_nettype none
package pbm_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam logic [16:0] ONE_FX = 17'h10000;
	localparam logic [35:0] HALF_FX = 36'h8000;
	localparam int unsigned ITER_STAGES = 17;

	typedef enum logic [3:0] {
		MODE_MEAN = 4'd0,
		MODE_GEOM = 4'd1,
		MODE_HARM = 4'd2,
		MODE_MUL = 4'd3,
		MODE_SCREEN = 4'd4,
		MODE_OVERLAY = 4'd5,
		MODE_HARD = 4'd6,
		MODE_SOFT = 4'd7,
		MODE_FADE = 4'd8
	} mode_t;

	// two square roots and one divide, advanced one digit per stage
	typedef struct packed {
		logic [33:0] v1;
		logic [34:0] r1;
		logic [33:0] v2;
		logic [34:0] r2;
		logic [33:0] rem;
		logic [17:0] d;
		logic [16:0] q;
	} iter_t;

	typedef struct packed {
		logic [3:0] func;
		logic a7;
		logic b7;
		logic zero;
		logic [16:0] fa;
		logic [16:0] fb;
		logic [16:0] mean;
		logic [17:0] mul;
		logic [17:0] twoab;
		logic [17:0] twop;
		logic [17:0] scr;
		logic [17:0] aa;
		logic [17:0] anb2;
		logic [16:0] k1;
		logic [16:0] k2;
	} side_t;

	// v*65536/255 = v*257 + v/255; the rounded fraction is one exactly when v >= 128
	function automatic logic [16:0] to_fx(logic [7:0] v);
		return {1'b0, v, v} + 17'(v[7]);
	endfunction

	function automatic logic [17:0] fx_rnd(logic [35:0] x);
		return 18'((x + HALF_FX) >> FRAC_BITS);
	endfunction

	function automatic iter_t iter_step(iter_t x, int unsigned k);
		logic [35:0] bitv;
		logic [35:0] trial;
		logic [34:0] dsh;
		iter_t y;
		y = x;
		bitv = 36'(1) << (2 * (ITER_STAGES - 1 - k));
		trial = 36'(x.r1) + bitv;
		if (36'(x.v1) >= trial) begin
			y.v1 = 34'(36'(x.v1) - trial);
			y.r1 = 35'((36'(x.r1) >> 1) + bitv);
		end else begin
			y.r1 = x.r1 >> 1;
		end
		trial = 36'(x.r2) + bitv;
		if (36'(x.v2) >= trial) begin
			y.v2 = 34'(36'(x.v2) - trial);
			y.r2 = 35'((36'(x.r2) >> 1) + bitv);
		end else begin
			y.r2 = x.r2 >> 1;
		end
		dsh = 35'(x.d) << (ITER_STAGES - 1 - k);
		if (35'(x.rem) >= dsh) begin
			y.rem = 34'(35'(x.rem) - dsh);
			y.q = x.q | (17'(1) << (ITER_STAGES - 1 - k));
		end
		return y;
	endfunction

endpackage
`default_nettype wire

/* rtl/pbm_iter.sv */
`default_nettype none
module pbm_iter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vld_in,
	input wire pbm_pkg::iter_t it_in,
	input wire pbm_pkg::side_t side_in,
	output logic vld_out,
	output pbm_pkg::iter_t it_out,
	output pbm_pkg::side_t side_out
);

	localparam int unsigned N = pbm_pkg::ITER_STAGES;

	logic vld_sx [N];
	pbm_pkg::iter_t it_sx [N];
	pbm_pkg::side_t side_sx [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic v_prev;
		pbm_pkg::iter_t it_prev;
		pbm_pkg::side_t side_prev;
		if (k == 0) begin : g_first
			assign v_prev = vld_in;
			assign it_prev = it_in;
			assign side_prev = side_in;
		end else begin : g_next
			assign v_prev = vld_sx[k-1];
			assign it_prev = it_sx[k-1];
			assign side_prev = side_sx[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sx[k] <= 1'b0;
			end else if (en) begin
				vld_sx[k] <= v_prev;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_sx[k] <= pbm_pkg::iter_step(it_prev, k);
				side_sx[k] <= side_prev;
			end
		end
	end

	assign vld_out = vld_sx[N-1];
	assign it_out = it_sx[N-1];
	assign side_out = side_sx[N-1];

endmodule
`default_nettype wire

/* rtl/pixel_blend_modes_top.sv */
`default_nettype none
// Per-channel blend of base_pixel with layer_pixel in one of nine modes, mixed
// with the base by the opacity register (reset 255, full layer). Fully
// pipelined: one request enters per clock when not stalled; the two square
// roots and the harmonic-mean divide run one digit per stage over 17 stages.
// Only a stalled output holds the pipe. Write opacity only while idle.
module pixel_blend_modes_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic opacity_we,
	input wire logic [7:0] opacity_wdata,
	input wire logic pix_valid,
	output logic pix_stall,
	input wire logic [3:0] func,
	input wire logic [7:0] base_pixel,
	input wire logic [7:0] layer_pixel,
	output logic res_valid,
	input wire logic res_stall,
	output logic [7:0] blended_pixel
);

	logic en;
	logic [16:0] o_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic res_valid_q;
	logic [7:0] res_q;

	logic [3:0] func_s1, func_s2;
	logic a7_s1, b7_s1, a7_s2, b7_s2;
	logic [16:0] fa_s1, fb_s1, fa_s2, fb_s2;
	logic [33:0] ab_s2, p_s2, aa_s2, anb_s2;

	pbm_pkg::iter_t it_s3, it_iter;
	pbm_pkg::side_t side_s3, side_iter, side_s4, side_s5;
	logic vld_iter;

	logic [17:0] geo_s4, sqa_s4, geo_s5;
	logic [16:0] harm_s4, harm_s5;
	logic [35:0] t1_s5, t2_s5;
	logic [18:0] c_s6;
	logic [16:0] fa_s6;
	logic [33:0] p1_s7;
	logic [35:0] p2_s7;
	logic [36:0] sum_s8;

	logic [18:0] c_nxt;
	logic [17:0] ovl_hi;
	logic [45:0] scaled;
	logic [13:0] rounded;

	assign en = !res_valid_q || !res_stall;
	assign pix_stall = !en;
	assign res_valid = res_valid_q;
	assign blended_pixel = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q <= pbm_pkg::ONE_FX;
		end else if (opacity_we) begin
			o_q <= pbm_pkg::to_fx(opacity_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_iter;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			res_valid_q <= vld_s8;
		end
	end

	// front: fixed-point conversion and first products
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			a7_s1 <= base_pixel[7];
			b7_s1 <= layer_pixel[7];
			fa_s1 <= pbm_pkg::to_fx(base_pixel);
			fb_s1 <= pbm_pkg::to_fx(layer_pixel);

			func_s2 <= func_s1;
			a7_s2 <= a7_s1;
			b7_s2 <= b7_s1;
			fa_s2 <= fa_s1;
			fb_s2 <= fb_s1;
			ab_s2 <= 34'(fa_s1) * 34'(fb_s1);
			p_s2 <= 34'(pbm_pkg::ONE_FX - fa_s1) * 34'(pbm_pkg::ONE_FX - fb_s1);
			aa_s2 <= 34'(fa_s1) * 34'(fa_s1);
			anb_s2 <= 34'(fa_s1) * 34'(pbm_pkg::ONE_FX - fb_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3.v1 <= ab_s2;
			it_s3.r1 <= '0;
			it_s3.v2 <= 34'(fa_s2) << pbm_pkg::FRAC_BITS;
			it_s3.r2 <= '0;
			it_s3.rem <= (ab_s2 << 1) + 34'((18'(fa_s2) + 18'(fb_s2)) >> 1);
			it_s3.d <= 18'(fa_s2) + 18'(fb_s2);
			it_s3.q <= '0;

			side_s3.func <= func_s2;
			side_s3.a7 <= a7_s2;
			side_s3.b7 <= b7_s2;
			side_s3.zero <= (fa_s2 == '0) || (fb_s2 == '0);
			side_s3.fa <= fa_s2;
			side_s3.fb <= fb_s2;
			side_s3.mean <= 17'((18'(fa_s2) + 18'(fb_s2) + 18'd1) >> 1);
			side_s3.mul <= pbm_pkg::fx_rnd(36'(ab_s2));
			side_s3.twoab <= pbm_pkg::fx_rnd(36'(ab_s2) << 1);
			side_s3.twop <= pbm_pkg::fx_rnd(36'(p_s2) << 1);
			side_s3.scr <= 18'(pbm_pkg::ONE_FX) - pbm_pkg::fx_rnd(36'(p_s2));
			side_s3.aa <= pbm_pkg::fx_rnd(36'(aa_s2));
			side_s3.anb2 <= pbm_pkg::fx_rnd(36'(anb_s2) << 1);
			side_s3.k1 <= ({fb_s2, 1'b0} > 18'(pbm_pkg::ONE_FX)) ? '0
				: 17'(18'(pbm_pkg::ONE_FX) - {fb_s2, 1'b0});
			side_s3.k2 <= ({fb_s2, 1'b0} > 18'(pbm_pkg::ONE_FX))
				? 17'({fb_s2, 1'b0} - 18'(pbm_pkg::ONE_FX)) : '0;
		end
	end

	pbm_iter u_iter (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_in(vld_s3),
		.it_in(it_s3),
		.side_in(side_s3),
		.vld_out(vld_iter),
		.it_out(it_iter),
		.side_out(side_iter)
	);

	// back: root rounding, second products, mode select, opacity mix
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_iter;
			geo_s4 <= 18'(it_iter.r1) + 18'(35'(it_iter.v1) > it_iter.r1);
			sqa_s4 <= 18'(it_iter.r2) + 18'(35'(it_iter.v2) > it_iter.r2);
			harm_s4 <= side_iter.zero ? '0 : it_iter.q;

			side_s5 <= side_s4;
			geo_s5 <= geo_s4;
			harm_s5 <= harm_s4;
			t1_s5 <= 36'(side_s4.aa) * 36'(side_s4.k1);
			t2_s5 <= 36'(sqa_s4) * 36'(side_s4.k2);

			c_s6 <= c_nxt;
			fa_s6 <= side_s5.fa;

			p1_s7 <= 34'(fa_s6) * 34'(pbm_pkg::ONE_FX - o_q);
			p2_s7 <= 36'(c_s6) * 36'(o_q);

			sum_s8 <= 37'(p1_s7) + 37'(p2_s7);

			res_q <= (rounded > 14'd255) ? 8'd255 : rounded[7:0];
		end
	end

	assign ovl_hi = (side_s5.twop > 18'(pbm_pkg::ONE_FX)) ? '0
		: 18'(pbm_pkg::ONE_FX) - side_s5.twop;

	always_comb begin
		case (pbm_pkg::mode_t'(side_s5.func))
			pbm_pkg::MODE_MEAN: c_nxt = 19'(side_s5.mean);
			pbm_pkg::MODE_GEOM: c_nxt = 19'(geo_s5);
			pbm_pkg::MODE_HARM: c_nxt = 19'(harm_s5);
			pbm_pkg::MODE_MUL: c_nxt = 19'(side_s5.mul);
			pbm_pkg::MODE_SCREEN: c_nxt = 19'(side_s5.scr);
			pbm_pkg::MODE_OVERLAY: c_nxt = side_s5.a7 ? 19'(ovl_hi) : 19'(side_s5.twoab);
			pbm_pkg::MODE_HARD: c_nxt = side_s5.b7 ? 19'(ovl_hi) : 19'(side_s5.twoab);
			pbm_pkg::MODE_SOFT: c_nxt = side_s5.b7
				? 19'(side_s5.anb2) + 19'(pbm_pkg::fx_rnd(t2_s5))
				: 19'(side_s5.twoab) + 19'(pbm_pkg::fx_rnd(t1_s5));
			pbm_pkg::MODE_FADE: c_nxt = 19'(side_s5.fb);
			default: c_nxt = 19'(side_s5.fa);
		endcase
	end

	assign scaled = (46'(sum_s8) << 8) - 46'(sum_s8) + (46'(1) << 31);
	assign rounded = 14'(scaled >> 32);

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s8 |=> res_valid_q)
		else $error("finished request lost at output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |=> $stable(vld_s8) && $stable(sum_s8))
		else $error("pipeline moved under output stall");

	a_harm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && side_s5.zero |-> harm_s5 == '0)
		else $error("harmonic mean not zero for zero input");

endmodule
`default_nettype wire

/* sim/pbm_checker.sv */
module pbm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic opacity_we,
	input wire logic [7:0] opacity_wdata,
	input wire logic pix_valid,
	input wire logic pix_stall,
	input wire logic [3:0] func,
	input wire logic [7:0] base_pixel,
	input wire logic [7:0] layer_pixel,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire logic [7:0] blended_pixel,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ONE = 64'd1 << pbm_pkg::FRAC_BITS;
	localparam logic [63:0] HALF = 64'd1 << (pbm_pkg::FRAC_BITS - 1);

	logic [7:0] opacity_q;
	logic [7:0] expected_pixels[$];

	function automatic logic [63:0] fx_of(logic [7:0] v);
		return (64'(v) * ONE + 64'd127) / 64'd255;
	endfunction

	function automatic logic [63:0] fmul(logic [63:0] x, logic [63:0] y);
		return (x * y + HALF) >> pbm_pkg::FRAC_BITS;
	endfunction

	function automatic logic [63:0] isqrt_rnd(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] bitv;
		r = 0;
		x = v;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x = x - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		if (x > r)
			r = r + 1;
		return r;
	endfunction

	function automatic logic [63:0] subz(logic [63:0] x, logic [63:0] y);
		return (x > y) ? x - y : 64'd0;
	endfunction

	function automatic logic [7:0] blend_pixel(logic [3:0] f, logic [7:0] a, logic [7:0] b,
		logic [7:0] op);
		logic [63:0] fa, fb, fo, c, s, r;
		fa = fx_of(a);
		fb = fx_of(b);
		fo = fx_of(op);
		case (f)
			pbm_pkg::MODE_MEAN: c = (fa + fb + 1) >> 1;
			pbm_pkg::MODE_GEOM: c = isqrt_rnd(fa * fb);
			pbm_pkg::MODE_HARM: c = (fa == 0 || fb == 0) ? 64'd0 :
				(2 * fa * fb + ((fa + fb) >> 1)) / (fa + fb);
			pbm_pkg::MODE_MUL: c = fmul(fa, fb);
			pbm_pkg::MODE_SCREEN: c = ONE - fmul(ONE - fa, ONE - fb);
			pbm_pkg::MODE_OVERLAY: c = (a < 128) ? fmul(2 * fa, fb) :
				subz(ONE, fmul(2 * (ONE - fa), ONE - fb));
			pbm_pkg::MODE_HARD: c = (b < 128) ? fmul(2 * fb, fa) :
				subz(ONE, fmul(2 * (ONE - fb), ONE - fa));
			pbm_pkg::MODE_SOFT: c = (b < 128) ?
				fmul(2 * fa, fb) + fmul(fmul(fa, fa), subz(ONE, 2 * fb)) :
				fmul(2 * fa, ONE - fb) +
				fmul(isqrt_rnd(fa << pbm_pkg::FRAC_BITS), subz(2 * fb, ONE));
			pbm_pkg::MODE_FADE: c = fb;
			default: c = fa;
		endcase
		s = fa * (ONE - fo) + c * fo;
		r = (s * 255 + (64'd1 << (2 * pbm_pkg::FRAC_BITS - 1))) >> (2 * pbm_pkg::FRAC_BITS);
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= 8'd255;
			errors <= 0;
			pending <= 0;
			expected_pixels.delete();
		end else begin
			if (opacity_we)
				opacity_q <= opacity_wdata;
			if (pix_valid && !pix_stall)
				expected_pixels = {expected_pixels,
					blend_pixel(func, base_pixel, layer_pixel, opacity_q)};
			if (res_valid && !res_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected result blended_pixel=%0d", blended_pixel);
					errors <= errors + 1;
				end else begin
					if (expected_pixels[0] !== blended_pixel) begin
						$error("blended_pixel expected %0d actual %0d", expected_pixels[0],
							blended_pixel);
						errors <= errors + 1;
					end
					void'(expected_pixels.pop_front());
				end
			end
			pending <= expected_pixels.size();
		end
	end
endmodule

/* sim/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic opacity_we = 0;
	logic [7:0] opacity_wdata = 0;
	logic pix_valid = 0;
	logic pix_stall;
	logic [3:0] func = 0;
	logic [7:0] base_pixel = 0;
	logic [7:0] layer_pixel = 0;
	logic res_valid;
	logic res_stall = 0;
	logic [7:0] blended_pixel;
	int errors;
	int pending;
	bit hold_long = 0;

	always #5 clk = ~clk;

	pixel_blend_modes_top dut (.*);
	pbm_checker u_chk (.*);

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic send_pixel(logic [3:0] f, logic [7:0] a, logic [7:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			pix_valid <= 0;
			repeat (g) @(posedge clk);
		end
		func <= f;
		base_pixel <= a;
		layer_pixel <= b;
		pix_valid <= 1;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
	endtask

	task automatic set_opacity(logic [7:0] v);
		pix_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		opacity_we <= 1;
		opacity_wdata <= v;
		@(posedge clk);
		opacity_we <= 0;
	endtask

	task automatic random_phase(int n);
		logic [3:0] f;
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			f = (p < 90) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
			send_pixel(f, 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				res_stall <= 1;
				repeat (80) @(posedge clk);
				res_stall <= 0;
				hold_long = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				g = gap_len();
				if (g > 0) begin
					res_stall <= 1;
					repeat (g) @(posedge clk);
					res_stall <= 0;
				end
			end
		end
	end

	initial begin
		logic [7:0] edge_vals[4];
		edge_vals = '{8'd0, 8'd127, 8'd128, 8'd255};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int f = 0; f < 16; f++)
			send_pixel(4'(f), edge_vals[f % 4], edge_vals[(f + 1) % 4]);
		send_pixel(pbm_pkg::MODE_HARM, 8'd0, 8'd200);
		send_pixel(pbm_pkg::MODE_HARM, 8'd200, 8'd0);
		send_pixel(pbm_pkg::MODE_SOFT, 8'd255, 8'd255);
		send_pixel(pbm_pkg::MODE_OVERLAY, 8'd128, 8'd0);
		send_pixel(pbm_pkg::MODE_HARD, 8'd0, 8'd128);
		hold_long = 1;
		random_phase(250);
		set_opacity(8'd0);
		random_phase(150);
		set_opacity(8'd255);
		random_phase(150);
		set_opacity(8'd128);
		random_phase(150);
		set_opacity(8'($urandom));
		hold_long = 1;
		random_phase(150);
		set_opacity(8'd1);
		random_phase(150);
		pix_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
